### design/escape_sequence_decoder_unit_macros.svh
// Assertion macros for the escape sequence decoder (used by esd_decode)
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH
`define ESD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("escape decoder check failed");
`define ESD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("escape decoder check failed");
`else
`define ESD_ASSERT(label, clk, rst, prop)
`define ESD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### design/esd_pkg.sv
// Types, status codes and helpers for the escape sequence decoder
package esd_pkg;

   localparam int CP_W  = 32;
   localparam int CNT_W = 4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_SHORT   = 2'd2;
   localparam logic [1:0] ST_NOBRACE = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic [1:0]      status;
      logic            byte_used;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // Return {is_hex, value} for one ASCII byte
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {["0":"9"]}) begin
         r = {1'b1, b[3:0]};
      end else if (b inside {["a":"f"], ["A":"F"]}) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

### design/esd_decode.sv
// Escape state register and per-byte decode logic
`include "escape_sequence_decoder_unit_macros.svh"

module esd_decode #(
   parameter int MAX_BRACE_DIGITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  esd_pkg::req_type    item,
   output esd_pkg::result_type result
);
   import esd_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_XFIRST  = 4'd1,
      MODE_XSECOND = 4'd2,
      MODE_XBRACE  = 4'd3,
      MODE_CTRL    = 4'd4,
      MODE_HEX4    = 4'd5,
      MODE_HEX8    = 4'd6,
      MODE_OCT     = 4'd7
   } mode_type;

   localparam logic [CNT_W-1:0] BRACE_LIMIT = CNT_W'(MAX_BRACE_DIGITS);

   mode_type         mode_ff, mode_in;
   logic [CP_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [4:0]       hex;
   logic [CP_W-1:0]  acc_hex;
   logic [CP_W-1:0]  acc_oct;
   logic [CNT_W-1:0] cnt_inc;
   logic [7:0]       b;
   logic             eot;

   assign b       = item.text_byte;
   assign eot     = item.end_of_text;
   assign hex     = hex_digit(b);
   assign acc_hex = {acc_ff[CP_W-5:0], hex[3:0]};
   assign acc_oct = {acc_ff[CP_W-4:0], b[2:0]};
   assign cnt_inc = cnt_ff + 1'b1;

   always_comb begin
      logic            emit;
      logic [CP_W-1:0] cp;
      logic [1:0]      st;
      logic            used;
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      emit    = 1'b0;
      cp      = '0;
      st      = ST_OK;
      used    = 1'b0;
      case (mode_ff)
         MODE_XFIRST: begin
            if (eot) begin
               emit = 1'b1; st = ST_SHORT;
            end else if (hex[4]) begin
               acc_in  = CP_W'(hex[3:0]);
               mode_in = MODE_XSECOND;
            end else if (b == "{") begin
               acc_in  = '0;
               cnt_in  = '0;
               mode_in = MODE_XBRACE;
            end else begin
               emit = 1'b1; st = ST_ILLEGAL; used = 1'b1;
            end
         end
         MODE_XSECOND: begin
            emit = 1'b1;
            if (!eot && hex[4]) begin
               cp = acc_hex; used = 1'b1;
            end else begin
               cp = acc_ff;
            end
         end
         MODE_XBRACE: begin
            if (eot) begin
               emit = 1'b1; st = ST_NOBRACE;
            end else if (b == "}") begin
               emit = 1'b1; cp = acc_ff; used = 1'b1;
            end else if (cnt_ff >= BRACE_LIMIT) begin
               emit = 1'b1; st = ST_NOBRACE; used = 1'b1;
            end else if (!hex[4]) begin
               emit = 1'b1; st = ST_ILLEGAL; used = 1'b1;
            end else begin
               acc_in = acc_hex;
               cnt_in = cnt_inc;
            end
         end
         MODE_CTRL: begin
            emit = 1'b1;
            if (eot) begin
               st = ST_SHORT;
            end else if (b inside {["A":"Z"]}) begin
               cp = CP_W'(b[4:0]); used = 1'b1;
            end else begin
               st = ST_ILLEGAL; used = 1'b1;
            end
         end
         MODE_HEX4, MODE_HEX8: begin
            if (eot) begin
               emit = 1'b1; st = ST_SHORT;
            end else if (!hex[4]) begin
               emit = 1'b1; st = ST_ILLEGAL; used = 1'b1;
            end else begin
               acc_in = acc_hex;
               cnt_in = cnt_inc;
               if (cnt_inc >= ((mode_ff == MODE_HEX4) ? CNT_W'(4) : CNT_W'(8))) begin
                  emit = 1'b1; cp = acc_hex; used = 1'b1;
               end
            end
         end
         MODE_OCT: begin
            if (!eot && (b inside {["0":"7"]})) begin
               acc_in = acc_oct;
               cnt_in = cnt_inc;
               if (cnt_inc >= CNT_W'(3)) begin
                  emit = 1'b1; cp = acc_oct; used = 1'b1;
               end
            end else begin
               emit = 1'b1; cp = acc_ff;
            end
         end
         default: begin
            // idle or an unreached mode: take the escape letter
            if (eot) begin
               emit = 1'b1; st = ST_SHORT;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               case (b)
                  "x":  mode_in = MODE_XFIRST;
                  "c":  mode_in = MODE_CTRL;
                  "u":  mode_in = MODE_HEX4;
                  "U":  mode_in = MODE_HEX8;
                  "a":  begin emit = 1'b1; cp = CP_W'(7);  used = 1'b1; end
                  "b":  begin emit = 1'b1; cp = CP_W'(8);  used = 1'b1; end
                  "t":  begin emit = 1'b1; cp = CP_W'(9);  used = 1'b1; end
                  "n":  begin emit = 1'b1; cp = CP_W'(10); used = 1'b1; end
                  "v":  begin emit = 1'b1; cp = CP_W'(11); used = 1'b1; end
                  "f":  begin emit = 1'b1; cp = CP_W'(12); used = 1'b1; end
                  "r":  begin emit = 1'b1; cp = CP_W'(13); used = 1'b1; end
                  "e":  begin emit = 1'b1; cp = CP_W'(27); used = 1'b1; end
                  default: begin
                     if (b inside {["0":"7"]}) begin
                        acc_in  = CP_W'(b[2:0]);
                        cnt_in  = CNT_W'(1);
                        mode_in = MODE_OCT;
                     end else begin
                        // backslash, quote and any other byte return themselves
                        emit = 1'b1; cp = CP_W'(b); used = 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
      if (emit) begin
         mode_in = MODE_IDLE;
         acc_in  = '0;
         cnt_in  = '0;
      end
      result.valid           = emit;
      result.data.code_point = cp;
      result.data.status     = st;
      result.data.byte_used  = used;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= '0;
         cnt_ff  <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
      end
   end

   `ESD_ASSERT(a_error_zero_cp, clock, reset, result.valid && result.data.status != ST_OK |-> result.data.code_point == '0)
   `ESD_ASSERT(a_emit_clears, clock, reset, step && result.valid |=> mode_ff == MODE_IDLE && acc_ff == '0 && cnt_ff == '0)
   `ESD_ASSERT(a_end_closes, clock, reset, step && item.end_of_text |-> result.valid && !result.data.byte_used)
   `ESD_ASSERT(a_count_bound, clock, reset, cnt_ff <= CNT_W'(8))

endmodule

### design/esd_rsp_reg.sv
// Result register that holds an item until the consumer takes it
module esd_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  esd_pkg::rsp_type load_data,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output esd_pkg::rsp_type rsp_data
);
   import esd_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
      if (can_load && load) begin
         data_ff <= load_data;
      end
   end

endmodule

### design/escape_sequence_decoder_unit.sv
// Top level of the escape sequence decoder: input register, decode and result register
//
// Feed the bytes that follow a backslash, one item each, with end_of_text set when the
// string has run out. The block takes one item per clock cycle while req_ready is
// high; a closing item passes the input register, then the result register; items
// that only extend an escape give no result. The rate is set by the escape state
// register (mode, 32-bit accumulator, digit count), which is updated once per byte
// by the decode logic. A result with byte_used low means the last byte was not part
// of the escape and must be presented again as ordinary text. A closing item waits
// in the input register while the result register stalls; req_ready falls only then.
module escape_sequence_decoder_unit #(
   parameter int MAX_BRACE_DIGITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  esd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output esd_pkg::rsp_type rsp_data
);
   import esd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   result_type result;
   logic       can_load;
   logic       advance;

   // An item that gives no result advances even when the result register is full
   assign advance     = in_valid_ff && (!result.valid || can_load);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   esd_decode #(
      .MAX_BRACE_DIGITS(MAX_BRACE_DIGITS)
   ) u_decode (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .result(result)
   );

   esd_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && result.valid),
      .load_data(result.data),
      .can_load (can_load),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

### tb/sv/tb.sv
// Self-checking bench for the escape sequence decoder: directed and random escapes, stalls
module tb;
   import esd_pkg::*;

   localparam int BRACE_LIMIT = 8;
   localparam int TARGET_ITEMS = 550;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   typedef enum logic [3:0] {
      M_IDLE, M_XFIRST, M_XSECOND, M_XBRACE, M_CTRL, M_HEX4, M_HEX8, M_OCT
   } esc_mode_e;

   typedef struct {
      req_type payload;
      bit      drain;
   } pend_item_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pend_item_t pending_q[$];
   rsp_type    decoded_q[$];
   bit         drain_next = 1'b0;
   int         total_items = 0;
   int         sent_cnt = 0;
   int         want_cnt = 0;
   int         got_cnt = 0;
   int         err_cnt = 0;
   int         send_gap = 0;
   int         stall_gap = 0;

   // decoder state as seen by the prediction
   esc_mode_e   mode_q = M_IDLE;
   logic [31:0] acc_q = '0;
   logic [3:0]  cnt_q = '0;

   escape_sequence_decoder_unit #(
      .MAX_BRACE_DIGITS(BRACE_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   function automatic int hex_val(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function automatic void close_escape(logic [31:0] cp, logic [1:0] st, logic used);
      rsp_type e;
      e.code_point = (st == ST_OK) ? cp : '0;
      e.status = st;
      e.byte_used = used;
      decoded_q.push_back(e);
      want_cnt++;
      mode_q = M_IDLE;
      acc_q = '0;
      cnt_q = '0;
   endfunction

   function automatic void decode_byte(req_type r);
      logic [7:0] b;
      logic       eot;
      int         h;
      b = r.text_byte;
      eot = r.end_of_text;
      h = hex_val(b);
      case (mode_q)
         M_XFIRST: begin
            if (eot) close_escape('0, ST_SHORT, 1'b0);
            else if (h >= 0) begin
               acc_q = 32'(h);
               mode_q = M_XSECOND;
            end else if (b == "{") begin
               acc_q = '0;
               cnt_q = '0;
               mode_q = M_XBRACE;
            end else close_escape('0, ST_ILLEGAL, 1'b1);
         end
         M_XSECOND: begin
            if (!eot && h >= 0) close_escape({acc_q[27:0], h[3:0]}, ST_OK, 1'b1);
            else close_escape(acc_q, ST_OK, 1'b0);
         end
         M_XBRACE: begin
            if (eot) close_escape('0, ST_NOBRACE, 1'b0);
            else if (b == "}") close_escape(acc_q, ST_OK, 1'b1);
            else if (int'(cnt_q) >= BRACE_LIMIT) close_escape('0, ST_NOBRACE, 1'b1);
            else if (h < 0) close_escape('0, ST_ILLEGAL, 1'b1);
            else begin
               acc_q = {acc_q[27:0], h[3:0]};
               cnt_q = cnt_q + 4'd1;
            end
         end
         M_CTRL: begin
            if (eot) close_escape('0, ST_SHORT, 1'b0);
            else if (b >= "A" && b <= "Z") close_escape(32'(b - "A") + 32'd1, ST_OK, 1'b1);
            else close_escape('0, ST_ILLEGAL, 1'b1);
         end
         M_HEX4, M_HEX8: begin
            if (eot) close_escape('0, ST_SHORT, 1'b0);
            else if (h < 0) close_escape('0, ST_ILLEGAL, 1'b1);
            else begin
               acc_q = {acc_q[27:0], h[3:0]};
               cnt_q = cnt_q + 4'd1;
               if (cnt_q >= ((mode_q == M_HEX4) ? 4'd4 : 4'd8))
                  close_escape(acc_q, ST_OK, 1'b1);
            end
         end
         M_OCT: begin
            if (!eot && b >= "0" && b <= "7") begin
               acc_q = {acc_q[28:0], b[2:0]};
               cnt_q = cnt_q + 4'd1;
               if (cnt_q >= 4'd3) close_escape(acc_q, ST_OK, 1'b1);
            end else close_escape(acc_q, ST_OK, 1'b0);
         end
         default: begin
            // idle: this byte picks the escape
            if (eot) close_escape('0, ST_SHORT, 1'b0);
            else begin
               acc_q = '0;
               cnt_q = '0;
               case (b)
                  "x":       mode_q = M_XFIRST;
                  "c":       mode_q = M_CTRL;
                  "u":       mode_q = M_HEX4;
                  "U":       mode_q = M_HEX8;
                  "a":       close_escape(32'd7, ST_OK, 1'b1);
                  "b":       close_escape(32'd8, ST_OK, 1'b1);
                  "t":       close_escape(32'd9, ST_OK, 1'b1);
                  "n":       close_escape(32'd10, ST_OK, 1'b1);
                  "v":       close_escape(32'd11, ST_OK, 1'b1);
                  "f":       close_escape(32'd12, ST_OK, 1'b1);
                  "r":       close_escape(32'd13, ST_OK, 1'b1);
                  "e":       close_escape(32'd27, ST_OK, 1'b1);
                  CH_BSLASH: close_escape(32'(CH_BSLASH), ST_OK, 1'b1);
                  CH_QUOTE:  close_escape(32'(CH_QUOTE), ST_OK, 1'b1);
                  default: begin
                     if (b >= "0" && b <= "7") begin
                        acc_q = 32'(b[2:0]);
                        cnt_q = 4'd1;
                        mode_q = M_OCT;
                     end else close_escape(32'(b), ST_OK, 1'b1);
                  end
               endcase
            end
         end
      endcase
   endfunction

   // no idling in the last part of the run, and a stretch without idling now and then
   function automatic bit idle_ok();
      return (sent_cnt + 60 < total_items) && ((sent_cnt / 80) % 4 != 3);
   endfunction

   always @(posedge clock) begin : drive
      logic       nv;
      pend_item_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data);
            sent_cnt <= sent_cnt + 1;
         end
         if (!req_valid || req_ready) begin
            nv = 1'b0;
            if (send_gap > 0) send_gap--;
            else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && want_cnt != got_cnt)) begin
               if (idle_ok() && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(0, 2);
               end else begin
                  nxt = pending_q.pop_front();
                  req_data <= nxt.payload;
                  nv = 1'b1;
               end
            end
            req_valid <= nv;
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      logic    nr;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_cnt <= got_cnt + 1;
            if (decoded_q.size() == 0) begin
               err_cnt++;
               $display("%0t: result with none expected, got cp=%h status=%0d used=%0b",
                        $time, rsp_data.code_point, rsp_data.status, rsp_data.byte_used);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.code_point !== want.code_point) begin
                  err_cnt++;
                  $display("%0t: code_point expected %h got %h",
                           $time, want.code_point, rsp_data.code_point);
               end
               if (rsp_data.status !== want.status) begin
                  err_cnt++;
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.byte_used !== want.byte_used) begin
                  err_cnt++;
                  $display("%0t: byte_used expected %0b got %0b",
                           $time, want.byte_used, rsp_data.byte_used);
               end
            end
         end
         nr = 1'b1;
         if (stall_gap > 0) begin
            stall_gap--;
            nr = 1'b0;
         end else if (idle_ok() && $urandom_range(0, 4) == 0) begin
            stall_gap = $urandom_range(0, 2);
            nr = 1'b0;
         end
         rsp_ready <= nr;
      end
   end

   task automatic put(logic [7:0] b, logic eot);
      pend_item_t p;
      p.payload.text_byte = b;
      p.payload.end_of_text = eot;
      p.drain = drain_next;
      drain_next = 1'b0;
      pending_q.push_back(p);
   endtask

   task automatic put_hex();
      string hex_chars;
      hex_chars = "0123456789abcdefABCDEF";
      put(hex_chars[$urandom_range(0, 21)], 1'b0);
   endtask

   // a byte that may or may not continue the escape, or the end of the string
   task automatic put_tail();
      case ($urandom_range(0, 2))
         0: put_hex();
         1: put(8'($urandom_range(0, 255)), 1'b0);
         default: put(8'($urandom_range(0, 255)), 1'b1);
      endcase
   endtask

   // n hex digits, now and then cut short by a bad byte or an early end
   task automatic put_digits(int n);
      bit cut;
      cut = 1'b0;
      for (int i = 0; i < n && !cut; i++) begin
         if ($urandom_range(0, 24) == 0) begin
            cut = 1'b1;
            put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else put_hex();
      end
   endtask

   task automatic put_escape();
      string letters;
      int    n;
      letters = "abtnvfre\\\"";
      case ($urandom_range(0, 15))
         0, 1: begin
            if ($urandom_range(0, 1) == 0) put(letters[$urandom_range(0, 9)], 1'b0);
            else put(8'($urandom_range(0, 255)), 1'b0);
         end
         2, 3: begin
            put("x", 1'b0);
            if ($urandom_range(0, 7) == 0) put_tail();
            else begin
               put_hex();
               put_tail();
            end
         end
         4, 5: begin
            put("x", 1'b0);
            put("{", 1'b0);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
            put_digits(n);
            if ($urandom_range(0, 4) != 0) put("}", 1'b0);
            else put_tail();
         end
         6: begin
            put("c", 1'b0);
            if ($urandom_range(0, 3) != 0) put(8'("A" + $urandom_range(0, 25)), 1'b0);
            else put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         7, 8: begin
            put("u", 1'b0);
            put_digits(4);
         end
         9, 10: begin
            put("U", 1'b0);
            put_digits(8);
         end
         11, 12: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) put(8'("0" + $urandom_range(0, 7)), 1'b0);
            if (n < 3) put_tail();
         end
         13: put(8'($urandom_range(0, 255)), 1'b1);
         default: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
         end
      endcase
   endtask

   initial begin : stimulus
      bit drained_mid;
      drained_mid = 1'b0;
      // directed: early ends, byte extremes, short, braced and four-digit hex, control, octal
      put(8'hA5, 1'b1);
      put(8'h00, 1'b0);
      put(8'hFF, 1'b0);
      put("x", 1'b0); put("4", 1'b0); put("G", 1'b0);
      put("x", 1'b0); put("{", 1'b0); put("}", 1'b0);
      put("x", 1'b0); put("g", 1'b0);
      put("c", 1'b0); put("Z", 1'b0);
      put("c", 1'b0); put(8'h5A, 1'b1);
      put("u", 1'b0); put("F", 1'b0); put("f", 1'b0); put("0", 1'b0); put("9", 1'b0);
      put("7", 1'b0); put("7", 1'b0); put("7", 1'b0);
      put("1", 1'b0); put(8'h00, 1'b1);
      put("x", 1'b0); put("{", 1'b0); put(8'hFF, 1'b1);
      drain_next = 1'b1;
      while (pending_q.size() < TARGET_ITEMS) begin
         if (!drained_mid && pending_q.size() > TARGET_ITEMS / 2) begin
            drained_mid = 1'b1;
            drain_next = 1'b1;
         end
         put_escape();
      end
      total_items = pending_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || want_cnt != got_cnt) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_cnt == 0 && decoded_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/esd_pkg.sv
design/esd_decode.sv
design/esd_rsp_reg.sv
design/escape_sequence_decoder_unit.sv
tb/sv/tb.sv
